[rtl/idv_pkg.sv]
// ----------------------------------------------------------------------------
// idv_pkg
// Shared types, constants and small functions for the identity number verifier.
// ----------------------------------------------------------------------------
package idv_pkg;

    localparam int ID_LENGTH = 18;
    localparam int POS_W     = 5;
    localparam int REGION_W  = 20;
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 7;
    localparam int DAY_W     = 7;
    localparam int SEQ_W     = 10;
    localparam int CFG_W     = 14;
    localparam int RCNT_W    = 7;

    // character positions where each field starts
    localparam logic [POS_W-1:0] POS_YEAR  = 5'd6;
    localparam logic [POS_W-1:0] POS_MONTH = 5'd10;
    localparam logic [POS_W-1:0] POS_DAY   = 5'd12;
    localparam logic [POS_W-1:0] POS_SEQ   = 5'd14;
    localparam logic [POS_W-1:0] POS_CHECK = 5'(ID_LENGTH - 1);

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_X = 8'h58;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_YEAR     = 2'd0;
    localparam logic [1:0] REG_MAX_YEAR     = 2'd1;
    localparam logic [1:0] REG_REGION_COUNT = 2'd2;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2011;

    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_MALE    = 2'd1;
    localparam logic [1:0] VERDICT_FEMALE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINAL
    } idv_state_t;

    typedef enum logic {
        ALU_MAC,
        ALU_EQ
    } idv_alu_op_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic take;
        logic char_item;
        logic last_char;
        logic search_done;
        logic out_free;
    } idv_status_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic in_ready;
        logic digit_en;
        logic issue_rd;
        logic finish;
    } idv_ctrl_t;

    // 2^(17-p) mod 11
    function automatic logic [3:0] weight_at(input logic [POS_W-1:0] p);
        logic [3:0] w;
        case (p)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // valid for v < 128
    function automatic logic [3:0] mod11(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd88) r = r - 8'd88;
        if (r >= 8'd44) r = r - 8'd44;
        if (r >= 8'd22) r = r - 8'd22;
        if (r >= 8'd11) r = r - 8'd11;
        return r[3:0];
    endfunction

    function automatic logic [4:0] mod25(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd200) r = r - 8'd200;
        if (r >= 8'd100) r = r - 8'd100;
        if (r >= 8'd50)  r = r - 8'd50;
        if (r >= 8'd25)  r = r - 8'd25;
        return r[4:0];
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] n;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
            7'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/idv_alu.sv]
// ----------------------------------------------------------------------------
// idv_alu
// Shared arithmetic unit: decimal shift-in (acc * 10 + digit) for every field
// accumulator, and the equality compare used by the region table search.
// ----------------------------------------------------------------------------
module idv_alu (
    input  idv_pkg::idv_alu_op_t          op,
    input  logic [idv_pkg::REGION_W-1:0]  a,
    input  logic [idv_pkg::REGION_W-1:0]  b,
    input  logic [3:0]                    digit,
    output logic [idv_pkg::REGION_W-1:0]  y,
    output logic                          eq
);

    // x*10 = x*8 + x*2, wraps to the accumulator width
    assign y  = (a << 3) + (a << 1) + idv_pkg::REGION_W'(digit);
    assign eq = (op == idv_pkg::ALU_EQ) && (a == b);

endmodule

[rtl/idv_ctrl.sv]
// ----------------------------------------------------------------------------
// idv_ctrl
// Sequencer: character step, region table sweep and verdict hand-off.
// ----------------------------------------------------------------------------
module idv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  idv_pkg::idv_status_t status,
    output idv_pkg::idv_ctrl_t   ctrl
);

    idv_pkg::idv_state_t state_reg;
    idv_pkg::idv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idv_pkg::ST_IDLE:
            begin
                if (status.take && status.char_item)
                begin
                    state_next = status.last_char ? idv_pkg::ST_SEARCH : idv_pkg::ST_DIGIT;
                end
            end
            idv_pkg::ST_DIGIT:  state_next = idv_pkg::ST_IDLE;
            idv_pkg::ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = idv_pkg::ST_DRAIN;
                end
            end
            idv_pkg::ST_DRAIN:  state_next = idv_pkg::ST_FINAL;
            idv_pkg::ST_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = idv_pkg::ST_IDLE;
                end
            end
            default:            state_next = idv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            idv_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
            idv_pkg::ST_DIGIT:  ctrl.digit_en = 1'b1;
            idv_pkg::ST_SEARCH: ctrl.issue_rd = !status.search_done;
            idv_pkg::ST_FINAL:  ctrl.finish   = status.out_free;
            default:            ctrl = '0;
        endcase
    end

endmodule

[rtl/id_number_verifier.sv]
// ----------------------------------------------------------------------------
// id_number_verifier
// Checks an 18-character resident identity number (mod 11-2 check character,
// region table, birth date and sequence) delivered one character per transfer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               content
//  s_axis    in   tvalid/tready           tuser: op; tdata: index, region, char
//  m_axis    out  tvalid/tready           tdata: verdict
//  cfg       in   cfg_we                  cfg_addr selects register, cfg_wdata
//
//  Table write: written as it is accepted. Characters 1..17: accept, then one
//  pass through the shared multiply-by-ten unit. Check character: accept, then
//  a sweep of the region memory read port, one entry per cycle, over
//  min(region_count, TABLE_DEPTH) entries, a last compare, then the verdict.
//  The verdict sits in an output register; only a following verdict waits on it.
//  Reset restores the registers and clears the number in progress; the table
//  contents are kept as they are and need writing before use.
// ----------------------------------------------------------------------------
module id_number_verifier #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [39:0]               s_axis_tdata,  // table_index, region_value, id_char
    input  logic [0:0]                s_axis_tuser,  // op
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // verdict
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [idv_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = ($clog2(TABLE_DEPTH + 1) > idv_pkg::RCNT_W) ?
                        $clog2(TABLE_DEPTH + 1) : idv_pkg::RCNT_W;

    // input fields
    logic [5:0]                    table_index;
    logic [idv_pkg::REGION_W-1:0]  region_value;
    logic [7:0]                    id_char;
    logic                          op;

    assign table_index  = s_axis_tdata[5:0];
    assign region_value = s_axis_tdata[25:6];
    assign id_char      = s_axis_tdata[33:26];
    assign op           = s_axis_tuser[0];

    // configuration
    logic [idv_pkg::YEAR_W-1:0]  min_year_reg;
    logic [idv_pkg::YEAR_W-1:0]  max_year_reg;
    logic [idv_pkg::RCNT_W-1:0]  region_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg     <= idv_pkg::MIN_YEAR_RST;
            max_year_reg     <= idv_pkg::MAX_YEAR_RST;
            region_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                idv_pkg::REG_MIN_YEAR:     min_year_reg     <= cfg_wdata;
                idv_pkg::REG_MAX_YEAR:     max_year_reg     <= cfg_wdata;
                idv_pkg::REG_REGION_COUNT: region_count_reg <= cfg_wdata[idv_pkg::RCNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // sequencer
    idv_pkg::idv_status_t status;
    idv_pkg::idv_ctrl_t   ctrl;
    logic                 take;

    idv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign take          = s_axis_tvalid && ctrl.in_ready;

    // number state
    logic [idv_pkg::POS_W-1:0]     pos_reg;
    logic [idv_pkg::REGION_W-1:0]  region_acc_reg;
    logic [idv_pkg::YEAR_W-1:0]    year_acc_reg;
    logic [idv_pkg::MONTH_W-1:0]   month_acc_reg;
    logic [idv_pkg::DAY_W-1:0]     day_acc_reg;
    logic [idv_pkg::SEQ_W-1:0]     seq_acc_reg;
    logic [3:0]                    csum_reg;
    logic [4:0]                    ymod25_reg;
    logic                          bad_reg;
    logic                          found_reg;
    logic [7:0]                    char_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          cmp_vld_reg;
    logic [idv_pkg::REGION_W-1:0]  rdata_reg;

    // region table
    logic [idv_pkg::REGION_W-1:0]  mem [TABLE_DEPTH];
    logic                          tbl_we;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;

    assign tbl_we  = take && (op == idv_pkg::OP_TABLE) && (32'(table_index) < TABLE_DEPTH);
    assign wr_addr = AW'(table_index);
    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            mem[wr_addr] <= region_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // search limit: entries beyond the table are never searched
    logic [CW-1:0] rc_ext;
    logic [CW-1:0] lim;

    assign rc_ext = CW'(region_count_reg);
    assign lim    = (rc_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : rc_ext;

    // character decode
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [idv_pkg::REGION_W-1:0]  acc_sel;
    logic [idv_pkg::REGION_W-1:0]  alu_a;
    logic [idv_pkg::REGION_W-1:0]  alu_y;
    logic                          alu_eq;
    idv_pkg::idv_alu_op_t          alu_op;
    logic [7:0]                    wsum;
    logic [7:0]                    ysum;

    always_comb
    begin
        is_digit = (char_reg >= idv_pkg::CH_0) && (char_reg <= idv_pkg::CH_9);
        digit    = is_digit ? 4'(char_reg - idv_pkg::CH_0) : 4'd0;
        if (pos_reg < idv_pkg::POS_YEAR)
        begin
            acc_sel = region_acc_reg;
        end
        else if (pos_reg < idv_pkg::POS_MONTH)
        begin
            acc_sel = idv_pkg::REGION_W'(year_acc_reg);
        end
        else if (pos_reg < idv_pkg::POS_DAY)
        begin
            acc_sel = idv_pkg::REGION_W'(month_acc_reg);
        end
        else if (pos_reg < idv_pkg::POS_SEQ)
        begin
            acc_sel = idv_pkg::REGION_W'(day_acc_reg);
        end
        else
        begin
            acc_sel = idv_pkg::REGION_W'(seq_acc_reg);
        end
        wsum = 8'(csum_reg) + 8'(digit * idv_pkg::weight_at(pos_reg));
        ysum = 8'({ymod25_reg, 3'b000}) + 8'({ymod25_reg, 1'b0}) + 8'(digit);
    end

    assign alu_op = cmp_vld_reg ? idv_pkg::ALU_EQ : idv_pkg::ALU_MAC;
    assign alu_a  = cmp_vld_reg ? rdata_reg : acc_sel;

    idv_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (region_acc_reg),
        .digit (digit),
        .y     (alu_y),
        .eq    (alu_eq)
    );

    // verdict
    logic [3:0]  chk;
    logic        chk_bad;
    logic [4:0]  chk_sum;
    logic        leap;
    logic [4:0]  dim;
    logic        ok;
    logic [1:0]  verdict_w;

    always_comb
    begin
        chk     = is_digit ? digit : ((char_reg == idv_pkg::CH_X) ? 4'd10 : 4'd0);
        chk_bad = !is_digit && (char_reg != idv_pkg::CH_X);
        chk_sum = 5'(csum_reg) + 5'(chk);
        // y%400==0 <=> y%16==0 and y%25==0; y%100!=0 given y%4==0 <=> y%25!=0
        leap    = (year_acc_reg[1:0] == 2'd0) &&
                  ((ymod25_reg != 5'd0) || (year_acc_reg[3:0] == 4'd0));
        dim     = idv_pkg::month_len(month_acc_reg) +
                  5'((month_acc_reg == 7'd2) && leap);
        ok      = !bad_reg && !chk_bad && found_reg &&
                  (year_acc_reg >= min_year_reg) && (year_acc_reg <= max_year_reg) &&
                  (month_acc_reg >= 7'd1) && (month_acc_reg <= 7'd12) &&
                  (day_acc_reg != 7'd0) && (day_acc_reg <= 7'(dim)) &&
                  (seq_acc_reg != 10'd0) &&
                  ((chk_sum == 5'd1) || (chk_sum == 5'd12));
        if (!ok)
        begin
            verdict_w = idv_pkg::VERDICT_INVALID;
        end
        else
        begin
            verdict_w = seq_acc_reg[0] ? idv_pkg::VERDICT_MALE : idv_pkg::VERDICT_FEMALE;
        end
    end

    // number accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            region_acc_reg <= '0;
            year_acc_reg   <= '0;
            month_acc_reg  <= '0;
            day_acc_reg    <= '0;
            seq_acc_reg    <= '0;
            csum_reg       <= '0;
            ymod25_reg     <= '0;
            bad_reg        <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            pos_reg        <= '0;
            region_acc_reg <= '0;
            year_acc_reg   <= '0;
            month_acc_reg  <= '0;
            day_acc_reg    <= '0;
            seq_acc_reg    <= '0;
            csum_reg       <= '0;
            ymod25_reg     <= '0;
            bad_reg        <= 1'b0;
        end
        else if (ctrl.digit_en)
        begin
            pos_reg  <= pos_reg + 5'd1;
            csum_reg <= idv_pkg::mod11(wsum);
            bad_reg  <= bad_reg || !is_digit;
            if (pos_reg < idv_pkg::POS_YEAR)
            begin
                region_acc_reg <= alu_y;
            end
            else if (pos_reg < idv_pkg::POS_MONTH)
            begin
                year_acc_reg <= alu_y[idv_pkg::YEAR_W-1:0];
                ymod25_reg   <= idv_pkg::mod25(ysum);
            end
            else if (pos_reg < idv_pkg::POS_DAY)
            begin
                month_acc_reg <= alu_y[idv_pkg::MONTH_W-1:0];
            end
            else if (pos_reg < idv_pkg::POS_SEQ)
            begin
                day_acc_reg <= alu_y[idv_pkg::DAY_W-1:0];
            end
            else
            begin
                seq_acc_reg <= alu_y[idv_pkg::SEQ_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= id_char;
        end
    end

    // region sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctrl.issue_rd;
            if (ctrl.finish)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.issue_rd)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (cmp_vld_reg && alu_eq)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    logic        out_valid_reg;
    logic [1:0]  verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            verdict_reg <= verdict_w;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, verdict_reg};

    assign status.take        = take;
    assign status.char_item   = (op == idv_pkg::OP_CHAR);
    assign status.last_char   = (pos_reg == idv_pkg::POS_CHECK);
    assign status.search_done = (cnt_reg == lim);
    assign status.out_free    = !out_valid_reg || m_axis_tready;

`ifndef SYNTHESIS
    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> m_axis_tvalid)
        else $error("verdict not presented after finish");

    a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lim)
        else $error("region sweep ran past the search limit");

    a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmp_vld_reg)
        else $error("table compare pending while accepting input");

    a_valid_needs_region: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (verdict_w != idv_pkg::VERDICT_INVALID)) |-> found_reg)
        else $error("valid verdict without region match");
`endif

endmodule

[dv/id_number_verifier_tb.sv]
// ----------------------------------------------------------------------------
// id_number_verifier_tb
// Self-checking bench for the identity number verifier. It loads the region
// table, writes the year and region-count registers, and streams numbers in
// one character per transfer. The numbers are well formed, deliberately
// corrupted or truncated. A local model of the checksum, date, region and
// sequence rules predicts each verdict. Every verdict transfer is compared
// with the oldest prediction, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module id_number_verifier_tb;

    localparam int TABLE_DEPTH = 64;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef logic [7:0] id_chars_t [idv_pkg::ID_LENGTH];

    typedef enum int {
        FLAW_CHECK,
        FLAW_BODY_CHAR,
        FLAW_CHECK_CHAR,
        FLAW_SEQ,
        FLAW_MONTH,
        FLAW_DAY,
        FLAW_YEAR,
        FLAW_REGION,
        FLAW_NONE
    } flaw_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [39:0]                  s_axis_tdata;   // table_index, region_value, id_char
    logic [0:0]                   s_axis_tuser;   // op
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [7:0]                   m_axis_tdata;   // verdict
    logic                         cfg_we;
    logic [1:0]                   cfg_addr;
    logic [idv_pkg::CFG_W-1:0]    cfg_wdata;

    // local copy of the block's registers, table and number in progress
    logic [idv_pkg::REGION_W-1:0] tbl_shadow [TABLE_DEPTH];
    logic [idv_pkg::YEAR_W-1:0]   lim_min_year;
    logic [idv_pkg::YEAR_W-1:0]   lim_max_year;
    logic [idv_pkg::RCNT_W-1:0]   lim_region_count;
    logic [idv_pkg::POS_W-1:0]    pos;
    logic [idv_pkg::REGION_W-1:0] acc_region;
    logic [idv_pkg::YEAR_W-1:0]   acc_year;
    logic [idv_pkg::MONTH_W-1:0]  acc_month;
    logic [idv_pkg::DAY_W-1:0]    acc_day;
    logic [idv_pkg::SEQ_W-1:0]    acc_seq;
    logic [3:0]                   acc_sum;
    bit                           saw_bad;

    logic [1:0]                   verdicts_due [$];
    int                           mismatches = 0;
    int                           items_sent = 0;
    bit                           src_gaps = 1'b1;
    bit                           sink_stalls = 1'b1;

    id_number_verifier #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int pos_weight(input int p);
        int w;
        w = 1;
        for (int k = p; k < idv_pkg::ID_LENGTH - 1; k++)
            w = (w * 2) % 11;
        return w;
    endfunction

    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int month_length(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic logic [1:0] number_verdict(input int chk);
        int n;
        bit known;
        n = (lim_region_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(lim_region_count);
        known = 1'b0;
        for (int i = 0; i < n; i++)
            if (tbl_shadow[i] == acc_region)
                known = 1'b1;
        if (saw_bad || !known)
            return idv_pkg::VERDICT_INVALID;
        if (acc_year < lim_min_year || acc_year > lim_max_year)
            return idv_pkg::VERDICT_INVALID;
        if (acc_month < 1 || acc_month > 12)
            return idv_pkg::VERDICT_INVALID;
        if (acc_day == 0 || acc_day > month_length(acc_month, acc_year))
            return idv_pkg::VERDICT_INVALID;
        if (acc_seq == 0)
            return idv_pkg::VERDICT_INVALID;
        if ((acc_sum + chk) % 11 != 1)
            return idv_pkg::VERDICT_INVALID;
        return acc_seq[0] ? idv_pkg::VERDICT_MALE : idv_pkg::VERDICT_FEMALE;
    endfunction

    task automatic track_item(input logic op, input logic [5:0] idx,
                              input logic [idv_pkg::REGION_W-1:0] region,
                              input logic [7:0] ch);
        int d;
        bit digit;
        if (op == idv_pkg::OP_TABLE)
        begin
            tbl_shadow[idx] = region;
            return;
        end
        digit = (ch >= idv_pkg::CH_0 && ch <= idv_pkg::CH_9);
        d = digit ? int'(ch - idv_pkg::CH_0) : 0;
        if (pos < idv_pkg::POS_CHECK)
        begin
            if (!digit)
                saw_bad = 1'b1;
            if (pos < idv_pkg::POS_YEAR)
                acc_region = idv_pkg::REGION_W'(acc_region * 10 + d);
            else if (pos < idv_pkg::POS_MONTH)
                acc_year = idv_pkg::YEAR_W'(acc_year * 10 + d);
            else if (pos < idv_pkg::POS_DAY)
                acc_month = idv_pkg::MONTH_W'(acc_month * 10 + d);
            else if (pos < idv_pkg::POS_SEQ)
                acc_day = idv_pkg::DAY_W'(acc_day * 10 + d);
            else
                acc_seq = idv_pkg::SEQ_W'(acc_seq * 10 + d);
            acc_sum = 4'((acc_sum + d * pos_weight(pos)) % 11);
            pos = pos + 1'b1;
        end
        else
        begin
            if (ch == idv_pkg::CH_X)
                d = 10;
            else if (!digit)
                saw_bad = 1'b1;
            verdicts_due.push_back(number_verdict(d));
            pos = '0;
            acc_region = '0;
            acc_year = '0;
            acc_month = '0;
            acc_day = '0;
            acc_seq = '0;
            acc_sum = '0;
            saw_bad = 1'b0;
        end
    endtask

    // ------------------------------------------------------------ stimulus

    function automatic logic [7:0] check_char(input int v);
        return (v == 10) ? idv_pkg::CH_X : idv_pkg::CH_0 + 8'(v);
    endfunction

    function automatic id_chars_t compose_id(input int region, input int year,
                                             input int month, input int day,
                                             input int seq);
        id_chars_t c;
        int vals [5];
        int lens [5];
        int p, v, sum;
        vals = '{region, year, month, day, seq};
        lens = '{6, 4, 2, 2, 3};
        p = 0;
        for (int f = 0; f < 5; f++)
        begin
            v = vals[f];
            for (int i = lens[f] - 1; i >= 0; i--)
            begin
                c[p + i] = idv_pkg::CH_0 + 8'(v % 10);
                v = v / 10;
            end
            p += lens[f];
        end
        sum = 0;
        for (int i = 0; i < idv_pkg::ID_LENGTH - 1; i++)
            sum = (sum + int'(c[i] - idv_pkg::CH_0) * pos_weight(i)) % 11;
        c[idv_pkg::ID_LENGTH-1] = check_char((12 - sum) % 11);
        return c;
    endfunction

    // well-formed number for the current settings, with at most one flaw
    function automatic id_chars_t draw_id();
        id_chars_t c;
        flaw_t flaw;
        int n, r, region, year, month, day, dim, seq, v;
        logic [7:0] b;
        r = $urandom_range(0, 15);
        flaw = (r < FLAW_NONE) ? flaw_t'(r) : FLAW_NONE;
        n = (lim_region_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(lim_region_count);
        if (n > 0 && flaw != FLAW_REGION)
            region = tbl_shadow[$urandom_range(0, n - 1)];
        else
            region = $urandom_range(0, 999999);
        if (lim_min_year > lim_max_year)
            year = $urandom_range(0, 9999);
        else
            case ($urandom_range(0, 3))
                0:       year = lim_min_year;
                1:       year = lim_max_year;
                default: year = $urandom_range(lim_min_year, lim_max_year);
            endcase
        if (flaw == FLAW_YEAR)
        begin
            if (lim_max_year < 9999)
                year = $urandom_range(lim_max_year + 1, 9999);
            else if (lim_min_year > 0)
                year = $urandom_range(0, lim_min_year - 1);
        end
        month = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(1, 12);
        if (flaw == FLAW_MONTH)
            month = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        dim = month_length(month, year);
        if (dim == 0)
            dim = 31;
        day = ($urandom_range(0, 2) == 0) ? dim : $urandom_range(1, dim);
        if (flaw == FLAW_DAY)
            day = $urandom_range(0, 1) ? 0 : $urandom_range(dim + 1, 99);
        seq = (flaw == FLAW_SEQ) ? 0 : $urandom_range(1, 999);
        c = compose_id(region, year, month, day, seq);
        case (flaw)
            FLAW_CHECK:
            begin
                v = (c[idv_pkg::ID_LENGTH-1] == idv_pkg::CH_X) ? 10 :
                    int'(c[idv_pkg::ID_LENGTH-1] - idv_pkg::CH_0);
                c[idv_pkg::ID_LENGTH-1] = check_char((v + $urandom_range(1, 10)) % 11);
            end
            FLAW_BODY_CHAR:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b >= idv_pkg::CH_0 && b <= idv_pkg::CH_9);
                c[$urandom_range(0, idv_pkg::ID_LENGTH - 2)] = b;
            end
            FLAW_CHECK_CHAR:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= idv_pkg::CH_0 && b <= idv_pkg::CH_9) || b == idv_pkg::CH_X);
                c[idv_pkg::ID_LENGTH-1] = b;
            end
            default: ;
        endcase
        return c;
    endfunction

    // one transfer on the input stream; valid is left high for a following item
    task automatic send_item(input logic op, input logic [5:0] idx,
                             input logic [idv_pkg::REGION_W-1:0] region,
                             input logic [7:0] ch);
        @(negedge clk);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {6'd0, ch, region, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_item(op, idx, region, ch);
        items_sent++;
    endtask

    // unused fields carry junk so that the block is seen to ignore them
    task automatic send_char(input logic [7:0] ch);
        send_item(idv_pkg::OP_CHAR, 6'($urandom), idv_pkg::REGION_W'($urandom), ch);
    endtask

    task automatic send_entry(input int idx, input int region);
        send_item(idv_pkg::OP_TABLE, 6'(idx), idv_pkg::REGION_W'(region), 8'($urandom));
    endtask

    task automatic send_id(input id_chars_t c, input int count = idv_pkg::ID_LENGTH);
        for (int i = 0; i < count; i++)
            send_char(c[i]);
    endtask

    // finish a number left part-way so the next one starts aligned
    task automatic pad_number();
        while (pos != 0)
            send_char(idv_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic drain_verdicts();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        // wait on past the last expected verdict, so that any extra one reaches the checker
        repeat (TABLE_DEPTH + 16) @(posedge clk);
    endtask

    // the input stream is held idle so no transfer overlaps the write
    task automatic write_reg(input logic [1:0] addr, input int value);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = idv_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (addr)
            idv_pkg::REG_MIN_YEAR:     lim_min_year = idv_pkg::YEAR_W'(value);
            idv_pkg::REG_MAX_YEAR:     lim_max_year = idv_pkg::YEAR_W'(value);
            idv_pkg::REG_REGION_COUNT: lim_region_count = idv_pkg::RCNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_limits(input int lo, input int hi, input int count);
        write_reg(idv_pkg::REG_MIN_YEAR, lo);
        write_reg(idv_pkg::REG_MAX_YEAR, hi);
        write_reg(idv_pkg::REG_REGION_COUNT, count);
    endtask

    // ---------------------------------------------------------------- tests

    // nothing can match with an empty search range
    task automatic test_empty_table();
        send_id(compose_id(110101, 1990, 6, 15, 123));
        drain_verdicts();
    endtask

    task automatic test_table_and_registers();
        id_chars_t c;
        int seq;
        send_entry(0, 110101);
        send_entry(1, 999999);
        write_reg(idv_pkg::REG_REGION_COUNT, 2);
        write_reg(REG_UNUSED, 14'h3FFF);
        send_id(compose_id(999999, idv_pkg::MAX_YEAR_RST, 12, 31, 999));
        seq = 0;
        do
        begin
            seq += 2;
            c = compose_id(110101, idv_pkg::MIN_YEAR_RST, 1, 1, seq);
        end
        while (c[idv_pkg::ID_LENGTH-1] != idv_pkg::CH_X);
        send_id(c);
        c[idv_pkg::ID_LENGTH-1] = idv_pkg::CH_0;
        send_id(c);
        drain_verdicts();
    endtask

    task automatic test_malformed_numbers();
        id_chars_t c;
        c = compose_id(110101, 1985, 3, 9, 217);
        c[3] = idv_pkg::CH_0 - 1'b1;
        send_id(c);
        c = compose_id(110101, 1985, 3, 9, 217);
        c[idv_pkg::ID_LENGTH-2] = idv_pkg::CH_9 + 1'b1;
        send_id(c);
        c = compose_id(110101, 1985, 3, 9, 217);
        if (c[idv_pkg::ID_LENGTH-1] == idv_pkg::CH_X)
            c[idv_pkg::ID_LENGTH-1] = CH_LOWER_X;
        else
            c[idv_pkg::ID_LENGTH-1] = 8'hFF;
        send_id(c);
        send_id(compose_id(110101, 1985, 3, 9, 0));
        send_id(compose_id(110101, 2000, 2, 29, 37));
        send_id(compose_id(110101, 1900, 2, 29, 37));   // century, not leap
        send_id(compose_id(110101, 1985, 13, 9, 217));
        send_id(compose_id(110101, 1985, 4, 31, 217));
        send_id(compose_id(110101, 1985, 4, 0, 217));
        drain_verdicts();
    endtask

    task automatic test_year_limits();
        set_limits(2012, 2000, 2);
        send_id(compose_id(110101, 2005, 5, 5, 55));
        drain_verdicts();
        set_limits(0, 9999, 2);
        send_id(compose_id(999999, 0, 2, 29, 1));
        send_id(compose_id(110101, 9999, 12, 31, 998));
        drain_verdicts();
        set_limits(1984, 1984, 2);
        send_id(compose_id(110101, 1984, 2, 29, 3));
        send_id(compose_id(110101, 1985, 1, 1, 3));
        drain_verdicts();
    endtask

    // whole table written, count past the depth searches every entry
    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_entry(i, i * 15873);
        set_limits(idv_pkg::MIN_YEAR_RST, idv_pkg::MAX_YEAR_RST, 127);
        send_id(compose_id(999999, 2001, 7, 7, 77));
        send_id(compose_id(0, 2001, 7, 7, 77));
        drain_verdicts();
        write_reg(idv_pkg::REG_REGION_COUNT, TABLE_DEPTH - 1);
        send_id(compose_id(999999, 2001, 7, 7, 77));
        drain_verdicts();
        write_reg(idv_pkg::REG_REGION_COUNT, TABLE_DEPTH);
        send_id(compose_id(999999, 2001, 7, 7, 77));
        drain_verdicts();
    endtask

    task automatic test_random_traffic();
        int goal, lo, hi, count, r;
        bit quiet;
        id_chars_t c;
        goal = items_sent + 500;
        while (items_sent < goal)
        begin
            pad_number();
            drain_verdicts();
            case ($urandom_range(0, 4))
                0:
                begin
                    lo = idv_pkg::MIN_YEAR_RST;
                    hi = idv_pkg::MAX_YEAR_RST;
                end
                1:
                begin
                    lo = 0;
                    hi = 9999;
                end
                2:
                begin
                    lo = $urandom_range(1, 9999);
                    hi = $urandom_range(0, lo - 1);
                end
                3:
                begin
                    lo = $urandom_range(0, 9999);
                    hi = lo;
                end
                default:
                begin
                    lo = $urandom_range(0, 9999);
                    hi = $urandom_range(lo, 9999);
                end
            endcase
            case ($urandom_range(0, 5))
                0:       count = 0;
                1:       count = 1;
                2:       count = TABLE_DEPTH;
                3:       count = 127;
                4:       count = $urandom_range(TABLE_DEPTH + 1, 127);
                default: count = $urandom_range(2, TABLE_DEPTH - 1);
            endcase
            set_limits(lo, hi, count);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, $urandom_range(0, 16383));
            // last stretch runs flat out
            quiet = (goal - items_sent) < 150;
            src_gaps = !quiet && $urandom_range(0, 3) != 0;
            sink_stalls = !quiet && $urandom_range(0, 3) != 0;
            repeat ($urandom_range(4, 10))
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    send_entry($urandom_range(0, TABLE_DEPTH - 1),
                               $urandom_range(0, 999999));
                end
                else if (r < 14)
                begin
                    repeat ($urandom_range(1, 4))
                        send_char(8'($urandom_range(0, 255)));
                end
                else if (r < 22)
                begin
                    pad_number();
                    c = draw_id();
                    send_id(c, $urandom_range(1, idv_pkg::ID_LENGTH - 1));
                end
                else
                begin
                    pad_number();
                    c = draw_id();
                    send_id(c);
                end
            end
        end
        pad_number();
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin : verdict_check
        logic [1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict: no transfer expected, got %0d", m_axis_tdata[1:0]);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[1:0] !== want)
                begin
                    $error("verdict: expected %0d, got %0d", want, m_axis_tdata[1:0]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial
    begin
        #(12 * 500_000);
        $display("id_number_verifier_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_shadow[i] = '0;
        lim_min_year     = idv_pkg::MIN_YEAR_RST;
        lim_max_year     = idv_pkg::MAX_YEAR_RST;
        lim_region_count = '0;
        pos        = '0;
        acc_region = '0;
        acc_year   = '0;
        acc_month  = '0;
        acc_day    = '0;
        acc_seq    = '0;
        acc_sum    = '0;
        saw_bad    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_table_and_registers();
        test_malformed_numbers();
        test_year_limits();
        test_full_table();
        test_random_traffic();

        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        drain_verdicts();
        if (mismatches == 0)
            $display("id_number_verifier_tb: PASS");
        else
            $display("id_number_verifier_tb: FAIL");
        $finish;
    end

endmodule
